FILE: rtl/bbd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bbd_pkg;

  localparam int MAX_WIDTH = 2048;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int WCFG_W    = 12;
  localparam int HCFG_W    = 16;
  localparam int ROW_W     = HCFG_W + 1;
  localparam int CNT_W     = (COL_W + 1 > WCFG_W) ? COL_W + 1 : WCFG_W;
  localparam int DATA_W    = 16;

  typedef enum logic {
    REG_WIDTH  = 1'b0,
    REG_HEIGHT = 1'b1
  } cfg_reg_t;

  // one item on its way from the counter stage to the interpolation stage
  typedef struct packed {
    logic       emit;
    logic       t;
    logic       b;
    logic       l;
    logic       r;
    logic       row_odd;
    logic       col_odd;
    logic       last;
    logic [7:0] pix;
  } s1_t;

endpackage

`default_nettype wire

FILE: rtl/bbd_linebuf.sv
`timescale 1ns / 1ps
`default_nettype none

module bbd_linebuf
  import bbd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire logic [COL_W-1:0] addr,
  input  wire logic [7:0]       pix,
  output logic      [7:0]       rd_pp,
  output logic      [7:0]       rd_p
);

  logic [7:0]       prev_line [MAX_WIDTH];
  logic [7:0]       prev_prev_line [MAX_WIDTH];
  logic             pend;
  logic [COL_W-1:0] pend_addr;

  // prev_line is read and overwritten at the same edge (old data out);
  // prev_prev_line takes the old prev_line value (via rd_p) at the following edge.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      rd_pp           <= prev_prev_line[addr];
      rd_p            <= prev_line[addr];
      prev_line[addr] <= pix;
    end
    if (pend) begin
      prev_prev_line[pend_addr] <= rd_p;
    end
    pend_addr <= addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
    end else begin
      pend <= wr_en;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bbd_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bbd_ctrl
  import bbd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_index,
  input  wire logic [DATA_W-1:0] cfg_data,
  input  wire logic              in_valid,
  input  wire logic              in_filler,
  input  wire logic [7:0]        in_pix,
  output logic                   in_ready,
  input  wire logic              s1_adv,
  output logic                   proceed,
  output logic      [COL_W-1:0]  col,
  output logic                   s1_valid,
  output s1_t                    s1
);

  logic [WCFG_W-1:0] eff_w;
  logic [HCFG_W-1:0] eff_h;
  logic [COL_W-1:0]  in_col, in_col_next, out_col, out_col_next;
  logic [ROW_W-1:0]  in_row, in_row_next;
  logic [HCFG_W-1:0] out_row, out_row_next;
  logic [CNT_W-1:0]  in_col_p1, out_col_p1, w_ext;
  logic [ROW_W-1:0]  out_row_p1, h_ext;
  logic [WCFG_W-1:0] w_raw;
  logic [HCFG_W-1:0] h_raw;
  logic              accept, emit, wrap, col_end, row_end, last, r_ok;
  s1_t               s1_next;

  assign cfg_ready = 1'b1;
  assign w_raw     = cfg_data[WCFG_W-1:0];
  assign h_raw     = cfg_data[HCFG_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_w <= WCFG_W'(256);
      eff_h <= HCFG_W'(256);
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_WIDTH: begin
          if (w_raw < WCFG_W'(2)) begin
            eff_w <= WCFG_W'(2);
          end else if (CNT_W'(w_raw) > CNT_W'(MAX_WIDTH)) begin
            eff_w <= WCFG_W'(MAX_WIDTH);
          end else begin
            eff_w <= w_raw;
          end
        end
        REG_HEIGHT: begin
          eff_h <= (h_raw < HCFG_W'(2)) ? HCFG_W'(2) : h_raw;
        end
        default: begin
        end
      endcase
    end
  end

  assign in_ready = !s1_valid || s1_adv;
  assign accept   = in_valid && in_ready;
  assign w_ext    = CNT_W'(eff_w);
  assign h_ext    = ROW_W'(eff_h);
  assign proceed  = accept && !(in_filler && (in_row < h_ext));
  assign col      = in_col;

  assign emit       = (in_row >= ROW_W'(2)) || ((in_row == ROW_W'(1)) && (in_col != '0));
  assign wrap       = (in_col == '0);
  assign in_col_p1  = CNT_W'(in_col) + CNT_W'(1);
  assign out_col_p1 = CNT_W'(out_col) + CNT_W'(1);
  assign out_row_p1 = ROW_W'(out_row) + ROW_W'(1);
  assign col_end    = out_col_p1 >= w_ext;
  assign row_end    = out_row_p1 >= h_ext;
  assign last       = col_end && row_end;
  assign r_ok       = !col_end && !wrap;

  always_comb begin
    if (in_col_p1 >= w_ext) begin
      in_col_next = '0;
      in_row_next = (in_row == '1) ? in_row : in_row + ROW_W'(1);
    end else begin
      in_col_next = in_col_p1[COL_W-1:0];
      in_row_next = in_row;
    end
    out_col_next = out_col;
    out_row_next = out_row;
    if (emit) begin
      if (last) begin
        in_col_next  = '0;
        in_row_next  = '0;
        out_col_next = '0;
        out_row_next = '0;
      end else if (col_end) begin
        out_col_next = '0;
        out_row_next = (out_row == '1) ? out_row : out_row + HCFG_W'(1);
      end else begin
        out_col_next = out_col_p1[COL_W-1:0];
      end
    end
  end

  always_comb begin
    s1_next.emit    = emit;
    s1_next.t       = (out_row != '0);
    s1_next.b       = !row_end;
    s1_next.l       = (out_col != '0);
    s1_next.r       = r_ok;
    s1_next.row_odd = out_row[0];
    s1_next.col_odd = out_col[0];
    s1_next.last    = last;
    s1_next.pix     = in_pix;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col   <= '0;
      in_row   <= '0;
      out_col  <= '0;
      out_row  <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (proceed) begin
        in_col   <= in_col_next;
        in_row   <= in_row_next;
        out_col  <= out_col_next;
        out_row  <= out_row_next;
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proceed) begin
      s1 <= s1_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bbd_interp.sv
`timescale 1ns / 1ps
`default_nettype none

module bbd_interp
  import bbd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s1_valid,
  input  wire s1_t         s1,
  input  wire logic [7:0]  rd_pp,
  input  wire logic [7:0]  rd_p,
  output logic             s1_adv,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [23:0] out_data,
  output logic             out_last
);

  // two older window columns (the newest is rd_pp, rd_p, s1.pix); row 0 is the top row
  logic [7:0] win_a [3];
  logic [7:0] win_b [3];
  logic [7:0] n00, n01, n02, n10, n11, n12, n20, n21, n22;
  logic [7:0] lr, tb, tblr, dg, red, grn, blu;
  logic [9:0] dsum;
  logic [2:0] dcnt;
  logic       tl, tr, bl, br, load;

  function automatic logic [7:0] pair_avg(input logic [7:0] a, input logic ha,
                                          input logic [7:0] b, input logic hb,
                                          input logic [7:0] ctr);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (ha && hb) begin
      return s[8:1];
    end else if (ha) begin
      return a;
    end else if (hb) begin
      return b;
    end
    return ctr;
  endfunction

  assign n00 = win_a[0];
  assign n01 = win_b[0];
  assign n02 = rd_pp;
  assign n10 = win_a[1];
  assign n11 = win_b[1];
  assign n12 = rd_p;
  assign n20 = win_a[2];
  assign n21 = win_b[2];
  assign n22 = s1.pix;

  assign lr   = pair_avg(n10, s1.l, n12, s1.r, n11);
  assign tb   = pair_avg(n01, s1.t, n21, s1.b, n11);
  assign tblr = 8'((({1'b0, lr} + {1'b0, tb}) >> 1));

  assign tl = s1.t && s1.l;
  assign tr = s1.t && s1.r;
  assign bl = s1.b && s1.l;
  assign br = s1.b && s1.r;

  assign dsum = (tl ? 10'(n00) : 10'd0) + (tr ? 10'(n02) : 10'd0)
              + (bl ? 10'(n20) : 10'd0) + (br ? 10'(n22) : 10'd0);
  assign dcnt = 3'(tl) + 3'(tr) + 3'(bl) + 3'(br);

  always_comb begin
    case (dcnt)
      3'd1:    dg = dsum[7:0];
      3'd2:    dg = dsum[8:1];
      3'd4:    dg = dsum[9:2];
      default: dg = n11;
    endcase
  end

  always_comb begin
    if (!s1.row_odd) begin
      if (!s1.col_odd) begin
        grn = n11; red = lr; blu = tb;
      end else begin
        red = n11; grn = tblr; blu = dg;
      end
    end else begin
      if (s1.col_odd) begin
        grn = n11; blu = lr; red = tb;
      end else begin
        blu = n11; grn = tblr; red = dg;
      end
    end
  end

  assign s1_adv = !s1.emit || !out_valid || out_ready;
  assign load   = s1_valid && s1_adv && s1.emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        win_a[i] <= '0;
        win_b[i] <= '0;
      end
    end else if (s1_valid && s1_adv) begin
      win_a    <= win_b;
      win_b[0] <= rd_pp;
      win_b[1] <= rd_p;
      win_b[2] <= s1.pix;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= {blu, grn, red};
      out_last <= s1.last;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/bayer_bilinear_demosaic.sv
// Bilinear demosaic for a GRBG Bayer stream (row 0: G R G R ..., row 1: B G B G ...).
// Input: raw 8-bit samples in raster order on the s_axis group; tuser marks a filler
// transaction. After each frame send image_width + 1 fillers to flush the last row;
// fillers sent while the frame is still arriving are dropped.
// Output: one RGB pixel per m_axis transaction, tlast on the final pixel of the frame.
// Pixel (row, col) leaves after the sample one line plus one pixel later is taken.
// Configuration: cfg_index 0 = image width (clamped to 2..2048), 1 = image height
// (at least 2); write only while the block is idle. cfg_ready is always high.
// Throughput: one transaction per cycle while m_axis is not held, set by the
// single-port-per-side line buffers which are read and written once per accepted
// sample. The sample completing a result is taken into the line buffer read registers
// and the s1 stage register; the result is loaded into the output register once that
// register is free or being taken.
// Stall: when m_axis is held, one more sample can enter the interpolation stage,
// after which s_axis_tready drops until the output register is taken.
// Reset (synchronous): clears counters, window and output valid and sets the
// size to 256 x 256. Line buffer contents are not cleared; entries not yet
// written only feed neighbors outside the image and are never used.
`timescale 1ns / 1ps
`default_nettype none

module bayer_bilinear_demosaic
  import bbd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [7:0]        s_axis_tdata,   // [7:0] raw_pixel
  input  wire logic              s_axis_tuser,   // [0] is_filler
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic      [23:0]       m_axis_tdata,   // [7:0] red, [15:8] green, [23:16] blue
  output logic                   m_axis_tlast,   // last_of_frame
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_index,
  input  wire logic [DATA_W-1:0] cfg_data
);

  logic             s1_adv, proceed, s1_valid;
  logic [COL_W-1:0] col;
  logic [7:0]       rd_pp, rd_p;
  s1_t              s1;

  bbd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_axis_tvalid),
    .in_filler (s_axis_tuser),
    .in_pix    (s_axis_tdata),
    .in_ready  (s_axis_tready),
    .s1_adv    (s1_adv),
    .proceed   (proceed),
    .col       (col),
    .s1_valid  (s1_valid),
    .s1        (s1)
  );

  bbd_linebuf u_linebuf (
    .clk   (clk),
    .rst   (rst),
    .wr_en (proceed),
    .addr  (col),
    .pix   (s_axis_tdata),
    .rd_pp (rd_pp),
    .rd_p  (rd_p)
  );

  bbd_interp u_interp (
    .clk       (clk),
    .rst       (rst),
    .s1_valid  (s1_valid),
    .s1        (s1),
    .rd_pp     (rd_pp),
    .rd_p      (rd_p),
    .s1_adv    (s1_adv),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

endmodule

`default_nettype wire

FILE: rtl/bbd_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module bbd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);

  // output register is empty right after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

  // an empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled while output register empty");

  // a new result always follows an input transaction, through the s1 and output registers
  a_rise_after_input: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
    else $error("result without a preceding input transaction");

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output changed");

endmodule

bind bayer_bilinear_demosaic bbd_checker u_bbd_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
